@@ hdl/dsma_pkg.sv @@
// ----------------------------------------------------------------------------
// Dust sensor moving average package
// Field widths, register indexes and register reset values shared by the
// block's files.
// ----------------------------------------------------------------------------
package dsma_pkg;

  localparam int SAMPLE_W   = 10;
  localparam int DENSITY_W  = 20;
  localparam int CFG_DATA_W = 20;
  localparam int CFG_IDX_W  = 2;

  typedef logic [SAMPLE_W-1:0]   sample_t;
  typedef logic [DENSITY_W-1:0]  density_t;
  typedef logic [CFG_IDX_W-1:0]  reg_index_t;

  localparam reg_index_t REG_THRESHOLD_CODE = 2'd0;
  localparam reg_index_t REG_GAIN           = 2'd1;
  localparam reg_index_t REG_OFFSET         = 2'd2;

  localparam sample_t  THRESHOLD_RESET = 10'd123;
  localparam sample_t  GAIN_RESET      = 10'd850;
  localparam density_t OFFSET_RESET    = 20'd102400;

endpackage

@@ hdl/dsma_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module dsma_ram #(
  parameter int WIDTH = 20,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic                                     re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hdl/dust_sensor_moving_average.sv @@
// ----------------------------------------------------------------------------
// Dust sensor moving average
// Converts converter samples to dust density and keeps a running-sum window
// average over the last WINDOW densities.
//
// Channel   Dir  Beat contents
// s_*       in   sample
// m_*       out  density_now, density_average
// cfg_*     in   register writes: threshold_code, gain, offset
//
// One sample is accepted every cycle unless the pipeline stalls; each sample
// passes through a five-register pipeline (a, b, c, d, output) that moves
// as a whole. The pipeline stalls only while a result waits in the output
// register. Reset is synchronous; the history window reads as zero after
// reset by per-entry valid bits, so no clearing pass is needed.
// ----------------------------------------------------------------------------
module dust_sensor_moving_average #(
  parameter int WINDOW = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [9:0] sample
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // [19:0] density_now, [39:20] density_average
  input  logic        cfg_we,
  input  logic [dsma_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dsma_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int SlotW   = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int LogW    = $clog2(WINDOW);
  localparam int SumW    = dsma_pkg::DENSITY_W + LogW;
  localparam int RecK    = SumW + LogW;
  localparam int RecMW   = SumW + 2;
  localparam longint RecM = ((longint'(1) << RecK) + WINDOW - 1) / WINDOW;
  localparam bit IsPow2  = (WINDOW & (WINDOW - 1)) == 0;
  localparam longint SumMax = longint'(WINDOW) * ((longint'(1) << dsma_pkg::DENSITY_W) - 1);

  dsma_pkg::sample_t  threshold_code;
  dsma_pkg::sample_t  gain;
  dsma_pkg::density_t offset;

  logic               adv;
  logic               a_valid;
  dsma_pkg::sample_t  a_sample;
  logic               b_valid;
  logic               b_above;
  dsma_pkg::density_t b_prod;
  logic [SlotW-1:0]   b_slot;
  logic               b_old_vld;
  logic               b_bypass;
  dsma_pkg::density_t b_bypass_val;
  dsma_pkg::density_t b_density;
  dsma_pkg::density_t b_old;
  logic               c_valid;
  dsma_pkg::density_t c_density;
  dsma_pkg::density_t c_old;
  logic               d_valid;
  dsma_pkg::density_t d_density;
  logic [SumW-1:0]    running_sum;
  logic [SumW-1:0]    running_sum_next;
  logic [SlotW-1:0]   slot;
  logic [SlotW-1:0]   slot_next;
  logic [WINDOW-1:0]  entry_vld;
  logic               ram_we;
  logic               collide;
  dsma_pkg::density_t ram_rdata;
  dsma_pkg::density_t avg_next;
  dsma_pkg::density_t out_density;
  dsma_pkg::density_t out_average;

  assign adv      = !m_tvalid || m_tready;
  assign s_tready = adv && !rst;
  assign m_tdata  = {out_average, out_density};

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold_code <= dsma_pkg::THRESHOLD_RESET;
      gain           <= dsma_pkg::GAIN_RESET;
      offset         <= dsma_pkg::OFFSET_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        dsma_pkg::REG_THRESHOLD_CODE: threshold_code <= cfg_data[dsma_pkg::SAMPLE_W-1:0];
        dsma_pkg::REG_GAIN:           gain           <= cfg_data[dsma_pkg::SAMPLE_W-1:0];
        dsma_pkg::REG_OFFSET:         offset         <= cfg_data;
        default: ;
      endcase
    end
  end

  assign slot_next = (slot == SlotW'(WINDOW - 1)) ? '0 : slot + 1'b1;
  assign ram_we    = adv && b_valid;
  assign collide   = ram_we && (b_slot == slot);

  always_comb begin
    b_density = '0;
    if (b_above && (b_prod > offset)) begin
      b_density = b_prod - offset;
    end
    if (b_bypass) begin
      b_old = b_bypass_val;
    end else if (b_old_vld) begin
      b_old = ram_rdata;
    end else begin
      b_old = '0;
    end
  end

  assign running_sum_next = running_sum - SumW'(c_old) + SumW'(c_density);

  dsma_ram #(
    .WIDTH(dsma_pkg::DENSITY_W),
    .DEPTH(WINDOW)
  ) u_history (
    .clk  (clk),
    .we   (ram_we),
    .waddr(b_slot),
    .wdata(b_density),
    .re   (adv),
    .raddr(slot),
    .rdata(ram_rdata)
  );

  generate
    if (IsPow2) begin : g_avg_shift
      assign avg_next = running_sum[LogW +: dsma_pkg::DENSITY_W];
    end else begin : g_avg_recip
      logic [SumW+RecMW-1:0] avg_prod;
      assign avg_prod = (SumW+RecMW)'(running_sum) * (SumW+RecMW)'(RecM[RecMW-1:0]);
      assign avg_next = avg_prod[RecK +: dsma_pkg::DENSITY_W];
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid     <= 1'b0;
      b_valid     <= 1'b0;
      c_valid     <= 1'b0;
      d_valid     <= 1'b0;
      m_tvalid    <= 1'b0;
      slot        <= '0;
      running_sum <= '0;
      entry_vld   <= '0;
    end else if (adv) begin
      a_valid  <= s_tvalid;
      b_valid  <= a_valid;
      c_valid  <= b_valid;
      d_valid  <= c_valid;
      m_tvalid <= d_valid;
      if (a_valid) begin
        slot <= slot_next;
      end
      if (b_valid) begin
        entry_vld[b_slot] <= 1'b1;
      end
      if (c_valid) begin
        running_sum <= running_sum_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_sample     <= s_tdata[dsma_pkg::SAMPLE_W-1:0];
      b_above      <= a_sample >= threshold_code;
      b_prod       <= {10'd0, gain} * {10'd0, a_sample};
      b_slot       <= slot;
      b_old_vld    <= entry_vld[slot];
      b_bypass     <= collide;
      b_bypass_val <= b_density;
      c_density    <= b_density;
      c_old        <= b_old;
      d_density    <= c_density;
      out_density  <= d_density;
      out_average  <= avg_next;
    end
  end

  a_slot_range: assert property (@(posedge clk) disable iff (rst)
    slot <= SlotW'(WINDOW - 1))
    else $error("window slot beyond window depth");

  a_sum_bound: assert property (@(posedge clk) disable iff (rst)
    longint'(running_sum) <= SumMax)
    else $error("running sum exceeds window capacity");

  a_old_in_sum: assert property (@(posedge clk) disable iff (rst)
    (c_valid && adv) |-> (SumW'(c_old) <= running_sum))
    else $error("retired entry larger than running sum");

  a_ready_rule: assert property (@(posedge clk) disable iff (rst)
    s_tready == (!m_tvalid || m_tready))
    else $error("input ready does not follow output stall");

endmodule

@@ dv/tb_dust_sensor_moving_average.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Dust sensor moving average testbench
// Drives converter samples through the stream input with random gaps and
// stalls, and writes the threshold, gain and offset registers between phases
// while the block is idle. A directed table covers reset values, extremes and
// boundary cases. Random phases follow. Every output beat is compared field by
// field with typed table values or a local density and window-sum predictor.
// ----------------------------------------------------------------------------
module tb_dust_sensor_moving_average;

  localparam int WINDOW = 16;
  localparam int HALF_PERIOD = 4;
  localparam int SETTLE_CYCLES = 8;
  localparam int NUM_PHASES = 8;
  localparam int PHASE_ITEMS = 55;
  localparam dsma_pkg::reg_index_t REG_UNUSED = 2'd3;

  typedef struct packed {
    dsma_pkg::density_t now;
    dsma_pkg::density_t avg;
  } density_pair_t;

  typedef enum logic {STEP_SAMPLE, STEP_WRITE} step_kind_t;

  typedef struct packed {
    step_kind_t           kind;
    dsma_pkg::reg_index_t idx;
    dsma_pkg::density_t   val;
    logic                 typed;
    dsma_pkg::density_t   now;
    dsma_pkg::density_t   avg;
  } directed_step_t;

  localparam int N_DIRECTED = 28;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        s_tvalid  = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata   = '0;
  logic        m_tvalid;
  logic        m_tready  = 1'b0;
  logic [39:0] m_tdata;
  logic        cfg_we    = 1'b0;
  dsma_pkg::reg_index_t cfg_index = '0;
  logic [dsma_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  dsma_pkg::sample_t  cur_threshold = dsma_pkg::THRESHOLD_RESET;
  dsma_pkg::sample_t  cur_gain      = dsma_pkg::GAIN_RESET;
  dsma_pkg::density_t cur_offset    = dsma_pkg::OFFSET_RESET;
  dsma_pkg::density_t win_hist [WINDOW];
  int          win_slot = 0;
  logic [23:0] win_sum  = '0;

  density_pair_t expected_densities [$];
  int  n_fail    = 0;
  bit  tx_steady = 1'b0;
  bit  rx_steady = 1'b0;
  int  rdy_cnt   = 0;

  directed_step_t directed_steps [N_DIRECTED] = '{
    '{STEP_SAMPLE, dsma_pkg::REG_THRESHOLD_CODE, 20'd0,      1'b1, 20'd0,      20'd0},
    '{STEP_SAMPLE, dsma_pkg::REG_THRESHOLD_CODE, 20'd122,    1'b1, 20'd0,      20'd0},
    '{STEP_SAMPLE, dsma_pkg::REG_THRESHOLD_CODE, 20'd1023,   1'b1, 20'd767150, 20'd47946},
    '{STEP_SAMPLE, dsma_pkg::REG_THRESHOLD_CODE, 20'd123,    1'b0, 20'd0,      20'd0},
    '{STEP_WRITE,  dsma_pkg::REG_THRESHOLD_CODE, 20'd0,      1'b0, 20'd0,      20'd0},
    '{STEP_WRITE,  dsma_pkg::REG_OFFSET,         20'd170000, 1'b0, 20'd0,      20'd0},
    '{STEP_SAMPLE, dsma_pkg::REG_THRESHOLD_CODE, 20'd0,      1'b0, 20'd0,      20'd0},
    '{STEP_SAMPLE, dsma_pkg::REG_THRESHOLD_CODE, 20'd200,    1'b0, 20'd0,      20'd0},
    '{STEP_SAMPLE, dsma_pkg::REG_THRESHOLD_CODE, 20'd201,    1'b0, 20'd0,      20'd0},
    '{STEP_WRITE,  dsma_pkg::REG_GAIN,           20'd1023,   1'b0, 20'd0,      20'd0},
    '{STEP_WRITE,  dsma_pkg::REG_OFFSET,         20'd0,      1'b0, 20'd0,      20'd0},
    '{STEP_SAMPLE, dsma_pkg::REG_THRESHOLD_CODE, 20'd1023,   1'b0, 20'd0,      20'd0},
    '{STEP_SAMPLE, dsma_pkg::REG_THRESHOLD_CODE, 20'd1,      1'b0, 20'd0,      20'd0},
    '{STEP_WRITE,  dsma_pkg::REG_GAIN,           20'd0,      1'b0, 20'd0,      20'd0},
    '{STEP_SAMPLE, dsma_pkg::REG_THRESHOLD_CODE, 20'd1023,   1'b0, 20'd0,      20'd0},
    '{STEP_WRITE,  dsma_pkg::REG_GAIN,           20'd1023,   1'b0, 20'd0,      20'd0},
    '{STEP_WRITE,  REG_UNUSED,                   20'hFFFFF,  1'b0, 20'd0,      20'd0},
    '{STEP_SAMPLE, dsma_pkg::REG_THRESHOLD_CODE, 20'd512,    1'b0, 20'd0,      20'd0},
    '{STEP_WRITE,  dsma_pkg::REG_THRESHOLD_CODE, 20'hFFC7B,  1'b0, 20'd0,      20'd0},
    '{STEP_SAMPLE, dsma_pkg::REG_THRESHOLD_CODE, 20'd122,    1'b0, 20'd0,      20'd0},
    '{STEP_SAMPLE, dsma_pkg::REG_THRESHOLD_CODE, 20'd123,    1'b0, 20'd0,      20'd0},
    '{STEP_WRITE,  dsma_pkg::REG_OFFSET,         20'hFFFFF,  1'b0, 20'd0,      20'd0},
    '{STEP_SAMPLE, dsma_pkg::REG_THRESHOLD_CODE, 20'd1023,   1'b0, 20'd0,      20'd0},
    '{STEP_WRITE,  dsma_pkg::REG_THRESHOLD_CODE, 20'd1023,   1'b0, 20'd0,      20'd0},
    '{STEP_WRITE,  dsma_pkg::REG_OFFSET,         20'd102400, 1'b0, 20'd0,      20'd0},
    '{STEP_WRITE,  dsma_pkg::REG_GAIN,           20'd850,    1'b0, 20'd0,      20'd0},
    '{STEP_SAMPLE, dsma_pkg::REG_THRESHOLD_CODE, 20'd1022,   1'b0, 20'd0,      20'd0},
    '{STEP_SAMPLE, dsma_pkg::REG_THRESHOLD_CODE, 20'd1023,   1'b0, 20'd0,      20'd0}
  };

  dust_sensor_moving_average #(
    .WINDOW(WINDOW)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    #HALF_PERIOD clk = 1'b1;
    #HALF_PERIOD clk = 1'b0;
  end

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Density of one sample, pushed into the window; returns density and mean.
  function automatic density_pair_t window_update(dsma_pkg::sample_t s);
    dsma_pkg::density_t d;
    dsma_pkg::density_t prod;
    prod = dsma_pkg::density_t'(cur_gain) * dsma_pkg::density_t'(s);
    if (s < cur_threshold || prod <= cur_offset) d = '0;
    else d = prod - cur_offset;
    win_sum = win_sum - 24'(win_hist[win_slot]) + 24'(d);
    win_hist[win_slot] = d;
    win_slot = (win_slot == WINDOW - 1) ? 0 : win_slot + 1;
    return '{now: d, avg: dsma_pkg::density_t'(win_sum / WINDOW)};
  endfunction

  function automatic dsma_pkg::sample_t pick_sample();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return cur_threshold;
      3: return cur_threshold - 1'b1;
      default: return dsma_pkg::sample_t'($urandom_range(0, 1023));
    endcase
  endfunction

  task automatic send_sample(dsma_pkg::sample_t s, logic typed, dsma_pkg::density_t now,
                             dsma_pkg::density_t avg);
    density_pair_t pred;
    int gap;
    s_tdata  <= {6'b0, s};
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pred = window_update(s);
    expected_densities.push_back(typed ? density_pair_t'{now: now, avg: avg} : pred);
    gap = tx_steady ? 0 : idle_len();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic settle();
    s_tvalid <= 1'b0;
    while (expected_densities.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(dsma_pkg::reg_index_t idx, logic [dsma_pkg::CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      dsma_pkg::REG_THRESHOLD_CODE: cur_threshold = val[dsma_pkg::SAMPLE_W-1:0];
      dsma_pkg::REG_GAIN:           cur_gain      = val[dsma_pkg::SAMPLE_W-1:0];
      dsma_pkg::REG_OFFSET:         cur_offset    = val[dsma_pkg::DENSITY_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Output side: ready is high when steady, else toggles accept and stall runs.
  always @(posedge clk) begin
    int len;
    if (rx_steady) begin
      m_tready <= 1'b1;
      rdy_cnt = 0;
    end else if (rdy_cnt > 0) begin
      rdy_cnt--;
    end else if (m_tready) begin
      len = idle_len();
      if (len > 0) begin
        m_tready <= 1'b0;
        rdy_cnt = len - 1;
      end else begin
        rdy_cnt = $urandom_range(0, 15);
      end
    end else begin
      m_tready <= 1'b1;
      rdy_cnt = $urandom_range(0, 15);
    end
  end

  always @(posedge clk) begin
    density_pair_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_densities.size() == 0) begin
        $error("unexpected result beat: density_now %0d density_average %0d",
               m_tdata[19:0], m_tdata[39:20]);
        n_fail++;
      end else begin
        want = expected_densities.pop_front();
        if (m_tdata[19:0] !== want.now) begin
          $error("density_now: expected %0d, got %0d", want.now, m_tdata[19:0]);
          n_fail++;
        end
        if (m_tdata[39:20] !== want.avg) begin
          $error("density_average: expected %0d, got %0d", want.avg, m_tdata[39:20]);
          n_fail++;
        end
      end
    end
  end

  initial begin
    #4_000_000;
    $display("FAIL dust_sensor_moving_average");
    $finish;
  end

  initial begin
    dsma_pkg::sample_t thr;
    for (int i = 0; i < WINDOW; i++) win_hist[i] = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_steps[i]) begin
      if (directed_steps[i].kind == STEP_WRITE) begin
        settle();
        write_reg(directed_steps[i].idx, directed_steps[i].val);
      end else begin
        send_sample(directed_steps[i].val[dsma_pkg::SAMPLE_W-1:0], directed_steps[i].typed,
                    directed_steps[i].now, directed_steps[i].avg);
      end
    end

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      settle();
      tx_steady = ($urandom_range(0, 3) == 0);
      rx_steady = ($urandom_range(0, 3) == 0);
      if (phase == 0) begin
        // Largest product with nothing subtracted drives the mean to its top.
        write_reg(dsma_pkg::REG_THRESHOLD_CODE, '0);
        write_reg(dsma_pkg::REG_GAIN, 20'd1023);
        write_reg(dsma_pkg::REG_OFFSET, '0);
      end else if (phase == 1) begin
        write_reg(dsma_pkg::REG_THRESHOLD_CODE, {10'h3FF, dsma_pkg::THRESHOLD_RESET});
        write_reg(dsma_pkg::REG_GAIN, {10'h2AA, dsma_pkg::GAIN_RESET});
        write_reg(dsma_pkg::REG_OFFSET, dsma_pkg::OFFSET_RESET);
      end else begin
        thr = dsma_pkg::sample_t'($urandom_range(0, 1023) >> $urandom_range(0, 4));
        write_reg(dsma_pkg::REG_THRESHOLD_CODE, {10'($urandom), thr});
        write_reg(dsma_pkg::REG_GAIN, 20'($urandom));
        write_reg(dsma_pkg::REG_OFFSET,
                  20'($urandom_range(0, 1048575) >> $urandom_range(0, 6)));
        write_reg(REG_UNUSED, 20'($urandom));
      end
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        send_sample((phase == 0 && k < 20) ? dsma_pkg::sample_t'('1) : pick_sample(),
                    1'b0, '0, '0);
      end
    end

    s_tvalid <= 1'b0;
    while (expected_densities.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (n_fail == 0) begin
      $display("PASS dust_sensor_moving_average");
    end else begin
      $display("FAIL dust_sensor_moving_average");
    end
    $finish;
  end

endmodule

@@ dust_sensor_moving_average.f @@
hdl/dsma_pkg.sv
hdl/dsma_ram.sv
hdl/dust_sensor_moving_average.sv
dv/tb_dust_sensor_moving_average.sv
